@@ hw/rtl/rthc_pkg.sv @@
// Shared types, constants and the step table of the ray/triangle hit counter.
`default_nettype none
package rthc_pkg;

	localparam int unsigned MAX_HITS_DEFAULT = 65535;
	localparam int QUEUE_DEPTH = 2;
	localparam int STEP_LAST = 23;
	localparam int DIV_LAST = 47;

	typedef logic signed [31:0] q16_t;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X    = 3'd3;
	localparam logic [2:0] REG_DIR_Y    = 3'd4;
	localparam logic [2:0] REG_DIR_Z    = 3'd5;
	localparam logic [2:0] REG_PAR_THR  = 3'd6;
	localparam logic [2:0] REG_MIN_DIST = 3'd7;

	typedef struct packed {
		q16_t [2:0]  origin;
		q16_t [2:0]  dir;
		logic [30:0] par_thr;
		logic [30:0] min_dist;
	} ray_cfg_t;

	typedef struct packed {
		q16_t [2:0] e1;
		q16_t [2:0] e2;
		q16_t [2:0] s;
		logic       last;
	} item_t;

	// operand codes
	localparam logic [4:0] OP_D0 = 5'd0;
	localparam logic [4:0] OP_D1 = 5'd1;
	localparam logic [4:0] OP_D2 = 5'd2;
	localparam logic [4:0] OP_E10 = 5'd3;
	localparam logic [4:0] OP_E11 = 5'd4;
	localparam logic [4:0] OP_E12 = 5'd5;
	localparam logic [4:0] OP_E20 = 5'd6;
	localparam logic [4:0] OP_E21 = 5'd7;
	localparam logic [4:0] OP_E22 = 5'd8;
	localparam logic [4:0] OP_S0 = 5'd9;
	localparam logic [4:0] OP_S1 = 5'd10;
	localparam logic [4:0] OP_S2 = 5'd11;
	localparam logic [4:0] OP_H0 = 5'd12;
	localparam logic [4:0] OP_H1 = 5'd13;
	localparam logic [4:0] OP_H2 = 5'd14;
	localparam logic [4:0] OP_Q0 = 5'd15;
	localparam logic [4:0] OP_Q1 = 5'd16;
	localparam logic [4:0] OP_Q2 = 5'd17;
	localparam int OP_COUNT = 18;

	// destination codes
	localparam logic [3:0] DST_H0 = 4'd0;
	localparam logic [3:0] DST_H1 = 4'd1;
	localparam logic [3:0] DST_H2 = 4'd2;
	localparam logic [3:0] DST_DET = 4'd3;
	localparam logic [3:0] DST_Q0 = 4'd4;
	localparam logic [3:0] DST_Q1 = 4'd5;
	localparam logic [3:0] DST_Q2 = 4'd6;
	localparam logic [3:0] DST_UN = 4'd7;
	localparam logic [3:0] DST_VN = 4'd8;
	localparam logic [3:0] DST_TN = 4'd9;

	typedef struct packed {
		logic [4:0] a_sel;
		logic [4:0] b_sel;
		logic       sub;
		logic       first;
		logic       fin;
		logic [3:0] dst;
	} step_op_t;

	function automatic step_op_t mk(logic [4:0] a, logic [4:0] b, logic sub,
		logic first, logic fin, logic [3:0] dst);
		step_op_t r;
		r.a_sel = a;
		r.b_sel = b;
		r.sub = sub;
		r.first = first;
		r.fin = fin;
		r.dst = dst;
		return r;
	endfunction

	function automatic step_op_t step_op(logic [4:0] step);
		step_op_t r;
		unique case (step)
			5'd0:  r = mk(OP_D1, OP_E22, 1'b0, 1'b1, 1'b0, DST_H0);
			5'd1:  r = mk(OP_D2, OP_E21, 1'b1, 1'b0, 1'b1, DST_H0);
			5'd2:  r = mk(OP_D2, OP_E20, 1'b0, 1'b1, 1'b0, DST_H1);
			5'd3:  r = mk(OP_D0, OP_E22, 1'b1, 1'b0, 1'b1, DST_H1);
			5'd4:  r = mk(OP_D0, OP_E21, 1'b0, 1'b1, 1'b0, DST_H2);
			5'd5:  r = mk(OP_D1, OP_E20, 1'b1, 1'b0, 1'b1, DST_H2);
			5'd6:  r = mk(OP_E10, OP_H0, 1'b0, 1'b1, 1'b0, DST_DET);
			5'd7:  r = mk(OP_E11, OP_H1, 1'b0, 1'b0, 1'b0, DST_DET);
			5'd8:  r = mk(OP_E12, OP_H2, 1'b0, 1'b0, 1'b1, DST_DET);
			5'd9:  r = mk(OP_S1, OP_E12, 1'b0, 1'b1, 1'b0, DST_Q0);
			5'd10: r = mk(OP_S2, OP_E11, 1'b1, 1'b0, 1'b1, DST_Q0);
			5'd11: r = mk(OP_S2, OP_E10, 1'b0, 1'b1, 1'b0, DST_Q1);
			5'd12: r = mk(OP_S0, OP_E12, 1'b1, 1'b0, 1'b1, DST_Q1);
			5'd13: r = mk(OP_S0, OP_E11, 1'b0, 1'b1, 1'b0, DST_Q2);
			5'd14: r = mk(OP_S1, OP_E10, 1'b1, 1'b0, 1'b1, DST_Q2);
			5'd15: r = mk(OP_S0, OP_H0, 1'b0, 1'b1, 1'b0, DST_UN);
			5'd16: r = mk(OP_S1, OP_H1, 1'b0, 1'b0, 1'b0, DST_UN);
			5'd17: r = mk(OP_S2, OP_H2, 1'b0, 1'b0, 1'b1, DST_UN);
			5'd18: r = mk(OP_D0, OP_Q0, 1'b0, 1'b1, 1'b0, DST_VN);
			5'd19: r = mk(OP_D1, OP_Q1, 1'b0, 1'b0, 1'b0, DST_VN);
			5'd20: r = mk(OP_D2, OP_Q2, 1'b0, 1'b0, 1'b1, DST_VN);
			5'd21: r = mk(OP_E20, OP_Q0, 1'b0, 1'b1, 1'b0, DST_TN);
			5'd22: r = mk(OP_E21, OP_Q1, 1'b0, 1'b0, 1'b0, DST_TN);
			5'd23: r = mk(OP_E22, OP_Q2, 1'b0, 1'b0, 1'b1, DST_TN);
			default: r = mk(OP_D0, OP_D0, 1'b0, 1'b1, 1'b0, DST_H0);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rthc_front.sv @@
// Front end: forms the saturated edge and origin vectors of a triangle.
`default_nettype none
module rthc_front (
	input  rthc_pkg::ray_cfg_t cfg,
	input  rthc_pkg::q16_t     a_x,
	input  rthc_pkg::q16_t     a_y,
	input  rthc_pkg::q16_t     a_z,
	input  rthc_pkg::q16_t     b_x,
	input  rthc_pkg::q16_t     b_y,
	input  rthc_pkg::q16_t     b_z,
	input  rthc_pkg::q16_t     c_x,
	input  rthc_pkg::q16_t     c_y,
	input  rthc_pkg::q16_t     c_z,
	input  logic               last_triangle,
	output rthc_pkg::item_t    item
);

	function automatic rthc_pkg::q16_t sat_sub(rthc_pkg::q16_t x, rthc_pkg::q16_t y);
		logic signed [32:0] d;
		d = 33'(x) - 33'(y);
		if (d[32] != d[31])
			return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return d[31:0];
	endfunction

	always_comb begin
		item.e1[0] = sat_sub(b_x, a_x);
		item.e1[1] = sat_sub(b_y, a_y);
		item.e1[2] = sat_sub(b_z, a_z);
		item.e2[0] = sat_sub(c_x, a_x);
		item.e2[1] = sat_sub(c_y, a_y);
		item.e2[2] = sat_sub(c_z, a_z);
		item.s[0] = sat_sub(cfg.origin[0], a_x);
		item.s[1] = sat_sub(cfg.origin[1], a_y);
		item.s[2] = sat_sub(cfg.origin[2], a_z);
		item.last = last_triangle;
	end

endmodule
`default_nettype wire

@@ hw/rtl/rthc_queue.sv @@
// Short queue between the front end and the arithmetic back end.
`default_nettype none
module rthc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rthc_pkg::item_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rthc_pkg::item_t pop_data
);

	localparam int PTR_W = (rthc_pkg::QUEUE_DEPTH > 1) ? $clog2(rthc_pkg::QUEUE_DEPTH) : 1;
	localparam logic [PTR_W:0] FULL_CNT = (PTR_W + 1)'(rthc_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(rthc_pkg::QUEUE_DEPTH - 1);

	rthc_pkg::item_t  mem_q [rthc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/rthc_back.sv @@
// Back end: shared multiplier sequencer, serial divider, hit counter and result register.
`default_nettype none
module rthc_back #(
	parameter int unsigned MAX_HITS = rthc_pkg::MAX_HITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rthc_pkg::ray_cfg_t cfg,
	input  logic               item_valid,
	output logic               item_ready,
	input  rthc_pkg::item_t    item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [30:0]        hit_distance,
	output logic [15:0]        hit_count,
	output logic               inside_res,
	output logic               result_last
);

	localparam logic [15:0] HIT_LIMIT = (MAX_HITS > 32'd65535) ? 16'hFFFF : 16'(MAX_HITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]         state_q;
	logic [4:0]         step_q;
	logic [5:0]         div_cnt_q;
	rthc_pkg::item_t    item_q;
	logic signed [31:0] h_q [3];
	logic signed [31:0] qv_q [3];
	logic signed [31:0] det_q;
	logic signed [31:0] un_q;
	logic signed [31:0] vn_q;
	logic signed [31:0] tn_q;
	logic signed [63:0] prod_q;
	logic signed [50:0] acc_q;
	logic [31:0]        den_q;
	logic [33:0]        rem_q;
	logic [47:0]        num_q;
	logic               ok_q;
	logic [15:0]        cnt_q;
	logic               par_q;
	logic               out_valid_q;
	logic               hit_q;
	logic [30:0]        dist_q;
	logic [15:0]        count_q;
	logic               inside_q;
	logic               last_res_q;

	rthc_pkg::step_op_t op;
	logic signed [31:0] opv [rthc_pkg::OP_COUNT];
	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [47:0] term;
	logic signed [50:0] acc_base;
	logic signed [50:0] acc_sum;
	logic signed [31:0] acc_sat;
	logic signed [32:0] detn;
	logic signed [32:0] unn;
	logic signed [32:0] vnn;
	logic signed [32:0] tnn;
	logic signed [33:0] sum_uv;
	logic signed [32:0] thr_s;
	logic               pass;
	logic [33:0]        rem_sh;
	logic               ge;
	logic [30:0]        t_sat;
	logic               hit_now;
	logic [15:0]        cnt_next;
	logic               par_next;
	logic               out_free;

	assign op = rthc_pkg::step_op(step_q);

	always_comb begin
		opv[rthc_pkg::OP_D0] = cfg.dir[0];
		opv[rthc_pkg::OP_D1] = cfg.dir[1];
		opv[rthc_pkg::OP_D2] = cfg.dir[2];
		opv[rthc_pkg::OP_E10] = item_q.e1[0];
		opv[rthc_pkg::OP_E11] = item_q.e1[1];
		opv[rthc_pkg::OP_E12] = item_q.e1[2];
		opv[rthc_pkg::OP_E20] = item_q.e2[0];
		opv[rthc_pkg::OP_E21] = item_q.e2[1];
		opv[rthc_pkg::OP_E22] = item_q.e2[2];
		opv[rthc_pkg::OP_S0] = item_q.s[0];
		opv[rthc_pkg::OP_S1] = item_q.s[1];
		opv[rthc_pkg::OP_S2] = item_q.s[2];
		opv[rthc_pkg::OP_H0] = h_q[0];
		opv[rthc_pkg::OP_H1] = h_q[1];
		opv[rthc_pkg::OP_H2] = h_q[2];
		opv[rthc_pkg::OP_Q0] = qv_q[0];
		opv[rthc_pkg::OP_Q1] = qv_q[1];
		opv[rthc_pkg::OP_Q2] = qv_q[2];
	end

	assign op_a = opv[op.a_sel];
	assign op_b = opv[op.b_sel];

	// floor of the product rescaled to Q16.16
	assign term = prod_q[63:16];
	assign acc_base = op.first ? 51'sd0 : acc_q;
	assign acc_sum = op.sub ? acc_base - 51'(term) : acc_base + 51'(term);

	always_comb begin
		if (acc_sum > 51'sd2147483647)
			acc_sat = 32'sh7FFF_FFFF;
		else if (acc_sum < -51'sd2147483648)
			acc_sat = 32'sh8000_0000;
		else
			acc_sat = acc_sum[31:0];
	end

	always_comb begin
		detn = det_q[31] ? -33'(det_q) : 33'(det_q);
		unn = det_q[31] ? -33'(un_q) : 33'(un_q);
		vnn = det_q[31] ? -33'(vn_q) : 33'(vn_q);
		tnn = det_q[31] ? -33'(tn_q) : 33'(tn_q);
		sum_uv = 34'(unn) + 34'(vnn);
		thr_s = $signed({2'b00, cfg.par_thr});
		pass = (det_q != 32'sd0) && !(detn < thr_s) && !unn[32] && !(unn > detn) &&
			!vnn[32] && !(sum_uv > 34'(detn)) && (tnn > 33'sd0);
	end

	assign rem_sh = {rem_q[32:0], num_q[47]};
	assign ge = (rem_sh >= {2'b00, den_q});

	assign t_sat = (num_q[47:31] != '0) ? 31'h7FFF_FFFF : num_q[30:0];
	assign hit_now = ok_q && (t_sat > cfg.min_dist);
	assign cnt_next = (hit_now && (cnt_q < HIT_LIMIT)) ? cnt_q + 16'd1 : cnt_q;
	assign par_next = par_q ^ hit_now;
	assign out_free = !out_valid_q || out_ready;

	assign item_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid)
					item_q <= item;
			end
			ST_MUL: begin
				prod_q <= op_a * op_b;
			end
			ST_ACC: begin
				acc_q <= acc_sum;
				if (op.fin) begin
					case (op.dst)
						rthc_pkg::DST_H0:  h_q[0] <= acc_sat;
						rthc_pkg::DST_H1:  h_q[1] <= acc_sat;
						rthc_pkg::DST_H2:  h_q[2] <= acc_sat;
						rthc_pkg::DST_DET: det_q <= acc_sat;
						rthc_pkg::DST_Q0:  qv_q[0] <= acc_sat;
						rthc_pkg::DST_Q1:  qv_q[1] <= acc_sat;
						rthc_pkg::DST_Q2:  qv_q[2] <= acc_sat;
						rthc_pkg::DST_UN:  un_q <= acc_sat;
						rthc_pkg::DST_VN:  vn_q <= acc_sat;
						default:           tn_q <= acc_sat;
					endcase
				end
			end
			ST_CHK: begin
				den_q <= detn[31:0];
				num_q <= {tnn[31:0], 16'h0000};
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? rem_sh - {2'b00, den_q} : rem_sh;
				num_q <= {num_q[46:0], ge};
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			hit_q <= hit_now;
			dist_q <= hit_now ? t_sat : '0;
			count_q <= cnt_next;
			inside_q <= item_q.last & par_next;
			last_res_q <= item_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			div_cnt_q <= '0;
			ok_q <= 1'b0;
			cnt_q <= '0;
			par_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						step_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (step_q == 5'(rthc_pkg::STEP_LAST)) begin
						state_q <= ST_CHK;
					end else begin
						step_q <= step_q + 5'd1;
						state_q <= ST_MUL;
					end
				end
				ST_CHK: begin
					ok_q <= pass;
					div_cnt_q <= '0;
					state_q <= pass ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'(rthc_pkg::DIV_LAST))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q <= item_q.last ? '0 : cnt_next;
						par_q <= item_q.last ? 1'b0 : par_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign hit_distance = dist_q;
	assign hit_count = count_q;
	assign inside_res = inside_q;
	assign result_last = last_res_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> den_q != '0)
		else $error("divider runs with zero divisor");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_q |-> dist_q != '0)
		else $error("hit reported with zero distance");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HIT_LIMIT)
		else $error("hit count above limit");

	a_inside_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_res_q |-> !inside_q)
		else $error("inside flag on a result that is not last");

endmodule
`default_nettype wire

@@ hw/rtl/ray_triangle_hit_counter.sv @@
// Usage:
//   Tests one ray, set through the register write channel, against a stream
//   of triangles (Moller-Trumbore, signed Q16.16).
//   Register channel: cfg_valid/cfg_ready, cfg_index selects the register,
//   cfg_data carries the value; cfg_ready is always high. Write only while
//   no request is in flight.
//   Input channel: in_valid/in_ready, one request per triangle plus a last
//   flag. Output channel: out_valid/out_ready, one result per request.
//   Steps: the queue, loading the back end, 24 products on the shared
//   multiplier (a multiply and an accumulate state each), a check state,
//   the one-bit-per-cycle divider when the range tests pass (skipped when
//   they reject the request), and loading the result register. The back
//   end takes no new request until its result is loaded; the two-entry
//   queue lets new requests land while it is busy.
//   Reset clears the registers to their defaults, the queue, the hit count
//   and parity, and the result valid flag; the result data is not reset.
//   A stalled receiver holds the result; the back end waits with the next
//   finished result and the queue fills, then in_ready drops.
`default_nettype none
module ray_triangle_hit_counter #(
	parameter int unsigned MAX_HITS = rthc_pkg::MAX_HITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	input  logic [31:0] c_x,
	input  logic [31:0] c_y,
	input  logic [31:0] c_z,
	input  logic        last_triangle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [30:0] hit_distance,
	output logic [15:0] hit_count,
	output logic        inside_res,
	output logic        result_last
);

	rthc_pkg::ray_cfg_t cfg_q;
	rthc_pkg::item_t    front_item;
	rthc_pkg::item_t    queue_item;
	logic               queue_valid;
	logic               queue_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin[0] <= '0;
			cfg_q.origin[1] <= '0;
			cfg_q.origin[2] <= '0;
			cfg_q.dir[0] <= 32'sd65536;
			cfg_q.dir[1] <= '0;
			cfg_q.dir[2] <= '0;
			cfg_q.par_thr <= 31'd1;
			cfg_q.min_dist <= 31'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rthc_pkg::REG_ORIGIN_X: cfg_q.origin[0] <= cfg_data;
				rthc_pkg::REG_ORIGIN_Y: cfg_q.origin[1] <= cfg_data;
				rthc_pkg::REG_ORIGIN_Z: cfg_q.origin[2] <= cfg_data;
				rthc_pkg::REG_DIR_X:    cfg_q.dir[0] <= cfg_data;
				rthc_pkg::REG_DIR_Y:    cfg_q.dir[1] <= cfg_data;
				rthc_pkg::REG_DIR_Z:    cfg_q.dir[2] <= cfg_data;
				rthc_pkg::REG_PAR_THR:  cfg_q.par_thr <= cfg_data[30:0];
				default:                cfg_q.min_dist <= cfg_data[30:0];
			endcase
		end
	end

	rthc_front u_front (
		.cfg           (cfg_q),
		.a_x           (a_x),
		.a_y           (a_y),
		.a_z           (a_z),
		.b_x           (b_x),
		.b_y           (b_y),
		.b_z           (b_z),
		.c_x           (c_x),
		.c_y           (c_y),
		.c_z           (c_z),
		.last_triangle (last_triangle),
		.item          (front_item)
	);

	rthc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_item)
	);

	rthc_back #(
		.MAX_HITS (MAX_HITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (queue_valid),
		.item_ready   (queue_ready),
		.item         (queue_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.hit_distance (hit_distance),
		.hit_count    (hit_count),
		.inside_res   (inside_res),
		.result_last  (result_last)
	);

endmodule
`default_nettype wire
